FILE: rtl/assert_macros.svh
// Assertion macros shared by the sampler voice RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define HLSV_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent that must hold at the clock edge after the antecedent.
`define HLSV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/hlsv_pkg.sv
// Shared types, codes and pitch tables of the looped sampler voice.
// Depends on nothing; used by the interfaces, the interpolator and the top level.
package hlsv_pkg;

  localparam int KIND_W     = 2;
  localparam int ADDR_W     = 16;
  localparam int SAMPLE_W   = 16;
  localparam int POS_W      = 16;
  localparam int SHIFT_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int Q24_W      = 25;

  // Input item kinds.
  localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RETRIG  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LP_FIRST   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LP_LIMIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFS  = 2'd3;

  localparam logic [POS_W-1:0] LP_LIMIT_RST = 16'hFFFF;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Four neighboring samples around the read position.
  typedef struct packed {
    sample_t xm1;
    sample_t x0;
    sample_t x1;
    sample_t x2;
  } taps_t;

  typedef struct packed {
    logic [3:0] oct;
    logic [3:0] rem;
  } semi_split_t;

  // 2^(r/12) in Q24, rounded.
  function automatic logic [Q24_W-1:0] semi_q24(input logic [3:0] r);
    logic [Q24_W-1:0] v;
    case (r)
      4'd0:    v = 25'd16777216;
      4'd1:    v = 25'd17774841;
      4'd2:    v = 25'd18831788;
      4'd3:    v = 25'd19951585;
      4'd4:    v = 25'd21137968;
      4'd5:    v = 25'd22394897;
      4'd6:    v = 25'd23726566;
      4'd7:    v = 25'd25137421;
      4'd8:    v = 25'd26632170;
      4'd9:    v = 25'd28215802;
      4'd10:   v = 25'd29893600;
      4'd11:   v = 25'd31671166;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Splits shift + 72 into octave and semitone by restoring subtraction of 12.
  function automatic semi_split_t semi_split(input logic [SHIFT_W-1:0] s);
    logic [7:0] sv;
    logic [3:0] oct;
    sv  = {s[SHIFT_W-1], s} + 8'd72;
    oct = '0;
    if (sv >= 8'd96) begin
      sv     = sv - 8'd96;
      oct[3] = 1'b1;
    end
    if (sv >= 8'd48) begin
      sv     = sv - 8'd48;
      oct[2] = 1'b1;
    end
    if (sv >= 8'd24) begin
      sv     = sv - 8'd24;
      oct[1] = 1'b1;
    end
    if (sv >= 8'd12) begin
      sv     = sv - 8'd12;
      oct[0] = 1'b1;
    end
    return '{oct: oct, rem: sv[3:0]};
  endfunction

endpackage

FILE: rtl/hlsv_if.sv
// Valid/ready channel interfaces of the sampler voice: input items, results, register writes.
// Depends on hlsv_pkg for field widths.
interface hlsv_in_if;
  import hlsv_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [ADDR_W-1:0]        sample_addr;
  logic signed [SAMPLE_W-1:0] sample_value;
  modport source (output valid, kind, sample_addr, sample_value, input ready);
  modport sink (input valid, kind, sample_addr, sample_value, output ready);
endinterface

interface hlsv_out_if;
  import hlsv_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] audio_out;
  modport source (output valid, audio_out, input ready);
  modport sink (input valid, audio_out, output ready);
endinterface

interface hlsv_cfg_if;
  import hlsv_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/hermite_looped_sample_voice_unit.sv
// Top level of the looped sampler voice: sample store, pitch phase, loop handling, output stage.
// Depends on hlsv_pkg, hlsv_if, hlsv_interp and assert_macros.svh.
//
// Channel   Modport  Payload                              Transfer when
// in_i      sink     kind, sample_addr, sample_value      in_i.valid & in_i.ready
// out_o     source   audio_out                            out_o.valid & out_o.ready
// cfg_i     sink     index, data                          cfg_i.valid (ready is always high)
//
// A sample write or a retrigger leaves the voice idle. A render tick on a running voice
// holds off the next item from its transfer until it is done: the four store
// reads share the single synchronous memory port, then the interpolator runs its three
// products through one multiplier. The first tick after reset or a retrigger skips both.
// Reset clears the phase and the registers only; the store is not cleared and holds
// garbage until written. A stalled output keeps its result in the output register while
// new writes and ticks are taken; a tick then waits for that register only at its end.
`include "assert_macros.svh"

module hermite_looped_sample_voice_unit #(
  parameter int unsigned STORE_DEPTH = 65536,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hlsv_in_if.sink     in_i,
  hlsv_out_if.source  out_o,
  hlsv_cfg_if.sink    cfg_i
);
  import hlsv_pkg::*;

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int INC_W = FRAC_BITS + 6;
  localparam int T_W   = FRAC_BITS + 7;
  localparam logic [AW-1:0]    LAST_ADDR = AW'(STORE_DEPTH - 1);
  localparam logic [INC_W-1:0] INC_RST   = INC_W'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ADDR, ST_READ, ST_DRAIN, ST_INTERP, ST_ADV, ST_OUT
  } state_e;

  // Address modulo the store depth. The quotient of a 16-bit address by a depth of
  // at least 256 fits in eight bits, so eight restoring steps are enough.
  function automatic logic [AW-1:0] depth_mod(input logic [ADDR_W-1:0] x);
    logic [23:0] r;
    r = {8'd0, x};
    for (int k = 7; k >= 0; k--) begin
      if (r >= (24'(STORE_DEPTH) << k)) begin
        r = r - (24'(STORE_DEPTH) << k);
      end
    end
    return r[AW-1:0];
  endfunction

  // Phase increment 2^(shift/12) in Q(FRAC_BITS), rounded half up when scaled down.
  function automatic logic [INC_W-1:0] pitch_inc(input logic [SHIFT_W-1:0] s);
    semi_split_t sp;
    logic [31:0] base;
    int          e;
    sp   = semi_split(s);
    base = 32'(semi_q24(sp.rem));
    e    = int'(sp.oct) + int'(FRAC_BITS) - 30;
    if (e >= 0) begin
      return INC_W'(base << e);
    end
    return INC_W'((base + (32'd1 << (-e - 1))) >> (-e));
  endfunction

  // Configuration registers. The shift is kept only as its phase increment.
  logic [INC_W-1:0] inc_q;
  logic [POS_W-1:0] lp_first_q, lp_limit_q, start_ofs_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q       <= INC_RST;
      lp_first_q  <= '0;
      lp_limit_q  <= LP_LIMIT_RST;
      start_ofs_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_SHIFT:     inc_q       <= pitch_inc(cfg_i.data[SHIFT_W-1:0]);
        CFG_LP_FIRST:  lp_first_q  <= cfg_i.data[POS_W-1:0];
        CFG_LP_LIMIT:  lp_limit_q  <= cfg_i.data[POS_W-1:0];
        CFG_START_OFS: start_ofs_q <= cfg_i.data[POS_W-1:0];
      endcase
    end
  end

  // Voice state and control.
  state_e               state_q;
  logic                 started_q;
  logic                 zero_q;
  logic [POS_W-1:0]     pos_q;
  logic [FRAC_BITS-1:0] frac_q;
  logic [AW-1:0]        raddr_q;
  logic [1:0]           cnt_q;
  logic                 rvld_q;
  sample_t              res_q;
  logic                 out_valid_q;
  sample_t              out_data_q;

  logic                 in_fire;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        wr_addr, mem_addr, base_addr;

  // The store has one port. Writes happen only in idle and reads only while the
  // read burst runs, so the state machine itself keeps them apart.
  sample_t store_mem [STORE_DEPTH];
  sample_t rdata_q;
  taps_t   taps_q;

  assign in_fire   = in_i.valid && in_i.ready;
  assign mem_we    = in_fire && (in_i.kind == KIND_WRITE);
  assign mem_re    = (state_q == ST_READ);
  assign wr_addr   = depth_mod(in_i.sample_addr);
  assign mem_addr  = mem_we ? wr_addr : raddr_q;
  assign base_addr = depth_mod(pos_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_addr] <= in_i.sample_value;
    end
    if (mem_re) begin
      rdata_q <= store_mem[mem_addr];
    end
  end

  // Read data arrive in the cycle after the address; shift them into the tap line.
  always_ff @(posedge clk_i) begin
    if (rvld_q) begin
      taps_q.xm1 <= taps_q.x0;
      taps_q.x0  <= taps_q.x1;
      taps_q.x1  <= taps_q.x2;
      taps_q.x2  <= rdata_q;
    end
  end

  // Interpolation of the current read position.
  logic    interp_done;
  sample_t interp_y;

  hlsv_interp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_DRAIN),
    .taps_i  (taps_q),
    .frac_i  (frac_q),
    .done_o  (interp_done),
    .y_o     (interp_y)
  );

  // Phase advance. The sum is compared against the loop limit before it wraps at 16 bits.
  logic [T_W-1:0]       t_sum;
  logic [POS_W:0]       p_sum;
  logic [POS_W-1:0]     pos_next;
  logic [FRAC_BITS-1:0] frac_next;

  always_comb begin
    t_sum     = T_W'(frac_q) + T_W'(inc_q);
    frac_next = t_sum[FRAC_BITS-1:0];
    p_sum     = {1'b0, pos_q} + (POS_W + 1)'(t_sum[T_W-1:FRAC_BITS]);
    if (p_sum >= {1'b0, lp_limit_q}) begin
      pos_next = p_sum[POS_W-1:0] - lp_limit_q + lp_first_q;
    end else begin
      pos_next = p_sum[POS_W-1:0];
    end
  end

  // The output register loads when a finished tick finds it empty or draining.
  logic out_load;

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      started_q   <= 1'b0;
      zero_q      <= 1'b0;
      pos_q       <= '0;
      frac_q      <= '0;
      raddr_q     <= '0;
      cnt_q       <= '0;
      rvld_q      <= 1'b0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      rvld_q <= mem_re;
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_data_q  <= res_q;
      end else if (out_o.valid && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_i.kind)
              KIND_TICK: begin
                if (started_q) begin
                  zero_q  <= 1'b0;
                  state_q <= ST_ADDR;
                end else begin
                  // First tick: load the start position and output silence.
                  pos_q     <= start_ofs_q;
                  frac_q    <= '0;
                  started_q <= 1'b1;
                  zero_q    <= 1'b1;
                  state_q   <= ST_ADV;
                end
              end
              KIND_RETRIG: started_q <= 1'b0;
              default: ;
            endcase
          end
        end
        ST_ADDR: begin
          // First tap sits one sample before the read position, wrapping at zero.
          raddr_q <= (base_addr == '0) ? LAST_ADDR : base_addr - AW'(1);
          cnt_q   <= '0;
          state_q <= ST_READ;
        end
        ST_READ: begin
          raddr_q <= (raddr_q == LAST_ADDR) ? '0 : raddr_q + AW'(1);
          cnt_q   <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: state_q <= ST_INTERP;
        ST_INTERP: begin
          if (interp_done) begin
            state_q <= ST_ADV;
          end
        end
        ST_ADV: begin
          pos_q   <= pos_next;
          frac_q  <= frac_next;
          res_q   <= zero_q ? sample_t'(0) : interp_y;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.audio_out = out_data_q;

  `HLSV_ASSERT(a_port_exclusive, clk_i, rst_ni, !(mem_we && mem_re), "store read and write in one cycle")
  `HLSV_ASSERT(a_raddr_range, clk_i, rst_ni, !mem_re || raddr_q <= LAST_ADDR, "read address past the store")
  `HLSV_ASSERT_NEXT(a_tick_blocks, clk_i, rst_ni, in_fire && in_i.kind == KIND_TICK, !in_i.ready, "input taken during a tick")
  `HLSV_ASSERT(a_done_in_interp, clk_i, rst_ni, !interp_done || state_q == ST_INTERP, "interpolator result unexpected")

endmodule

FILE: rtl/hlsv_interp.sv
// Four-point Hermite interpolator: one shared multiplier stepped over three products.
// Depends on hlsv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hlsv_interp #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  hlsv_pkg::taps_t       taps_i,
  input  logic [FRAC_BITS-1:0]  frac_i,
  output logic                  done_o,
  output hlsv_pkg::sample_t     y_o
);
  import hlsv_pkg::*;

  localparam int H_W    = 22;
  localparam int PROD_W = H_W + FRAC_BITS + 1;
  localparam logic signed [H_W-1:0] SAT_MAX = H_W'(32767);
  localparam logic signed [H_W-1:0] SAT_MIN = H_W'(-32768);

  typedef enum logic [2:0] {IS_IDLE, IS_M1, IS_M2, IS_M3, IS_FIN} step_e;

  step_e                    step_q;
  logic                     done_q;
  sample_t                  y_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;

  logic signed [H_W-1:0]    c, v, w, a, b, x0x2;
  logic signed [H_W-1:0]    prod_sh, h1, h2, h3, hr, mul_a;
  logic signed [FRAC_BITS:0] f_s;
  sample_t                  y_sat;

  // Coefficients; the taps stay put for the whole computation.
  always_comb begin
    c    = H_W'(taps_i.x1) - H_W'(taps_i.xm1);
    v    = (H_W'(taps_i.x0) - H_W'(taps_i.x1)) <<< 1;
    w    = c + v;
    a    = w + v + H_W'(taps_i.x2) - H_W'(taps_i.x0);
    b    = w + a;
    x0x2 = H_W'(taps_i.x0) <<< 1;
  end

  always_comb begin
    f_s     = $signed({1'b0, frac_i});
    prod_sh = H_W'(prod_q >>> FRAC_BITS);
    h1      = prod_sh - b;
    h2      = prod_sh + c;
    h3      = prod_sh + x0x2;
    hr      = (h3 + H_W'(1)) >>> 1;
    if (hr > SAT_MAX) begin
      y_sat = sample_t'(SAT_MAX);
    end else if (hr < SAT_MIN) begin
      y_sat = sample_t'(SAT_MIN);
    end else begin
      y_sat = sample_t'(hr);
    end
    case (step_q)
      IS_M1:   mul_a = a;
      IS_M2:   mul_a = h1;
      default: mul_a = h2;
    endcase
    prod_d = PROD_W'(mul_a) * PROD_W'(f_s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= IS_IDLE;
      done_q <= 1'b0;
      y_q    <= '0;
      prod_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (step_q)
        IS_IDLE: begin
          if (start_i) begin
            step_q <= IS_M1;
          end
        end
        IS_M1: begin
          prod_q <= prod_d;
          step_q <= IS_M2;
        end
        IS_M2: begin
          prod_q <= prod_d;
          step_q <= IS_M3;
        end
        IS_M3: begin
          prod_q <= prod_d;
          step_q <= IS_FIN;
        end
        IS_FIN: begin
          y_q    <= y_sat;
          done_q <= 1'b1;
          step_q <= IS_IDLE;
        end
        default: step_q <= IS_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign y_o    = y_q;

  `HLSV_ASSERT(a_start_when_idle, clk_i, rst_ni, !start_i || step_q == IS_IDLE, "interpolator started while busy")
  `HLSV_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_q, !done_q, "done held longer than one cycle")
  `HLSV_ASSERT(a_m1_from_start, clk_i, rst_ni, step_q != IS_M1 || $past(start_i), "first product without a start")

endmodule

FILE: tb/hermite_looped_sample_voice_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the looped sampler voice: directed and random item streams,
// an in-line voice predictor and an in-order result check. Depends on hlsv_pkg, the hlsv
// channel interfaces and the hermite_looped_sample_voice_unit RTL.
module hermite_looped_sample_voice_unit_tb;
  import hlsv_pkg::*;

  // The fourth kind code is undefined; the voice must drop such items without a result.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  // Cycles without any transfer on any channel before the run is declared hung.
  localparam int IDLE_LIMIT = 2000;
  // Margin that lets a trailing write or tick finish before the registers are touched or
  // the run is closed.
  localparam int SETTLE_CYCLES = 24;
  localparam int ITEM_COUNT = 1200;

  // Shadow of the voice. It tracks the store, the pitch phase and the loop handling, and
  // keeps the audio samples that accepted ticks are still owed.
  class voice_checker;
    logic [SHIFT_W-1:0]  shift;
    logic [POS_W-1:0]    lp_first;
    logic [POS_W-1:0]    lp_limit;
    logic [POS_W-1:0]    start_offset;
    bit signed [15:0]    store_mem [0:65535];
    bit                  written [0:65535];
    logic [POS_W-1:0]    position;
    logic [15:0]         fraction;
    bit                  started;
    logic signed [15:0]  expected_audio [$];
    int                  errors;

    function new();
      shift        = '0;
      lp_first     = '0;
      lp_limit     = LP_LIMIT_RST;
      start_offset = '0;
      position     = '0;
      fraction     = '0;
      started      = 1'b0;
      errors       = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    task report(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
    endtask

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SHIFT:     shift = data[SHIFT_W-1:0];
        CFG_LP_FIRST:  lp_first = data;
        CFG_LP_LIMIT:  lp_limit = data;
        CFG_START_OFS: start_offset = data;
        default: ;
      endcase
    endfunction

    // 2^(r/12) in Q24.
    function longint unsigned semitone_ratio(int r);
      case (r)
        0:       return 64'd16777216;
        1:       return 64'd17774841;
        2:       return 64'd18831788;
        3:       return 64'd19951585;
        4:       return 64'd21137968;
        5:       return 64'd22394897;
        6:       return 64'd23726566;
        7:       return 64'd25137421;
        8:       return 64'd26632170;
        9:       return 64'd28215802;
        10:      return 64'd29893600;
        default: return 64'd31671166;
      endcase
    endfunction

    // Phase increment in Q16: the Q24 ratio scaled by the octave, rounded half up when
    // the scaling drops bits.
    function longint unsigned pitch_step();
      int semis;
      int octave;
      int scale;
      longint unsigned ratio;
      semis  = $signed(shift);
      octave = (semis + 72) / 12 - 6;
      ratio  = semitone_ratio((semis + 72) % 12);
      scale  = octave - 8;
      if (scale >= 0) return ratio << scale;
      return (ratio + (64'd1 << (-scale - 1))) >> (-scale);
    endfunction

    function longint tap(int delta);
      logic [15:0] addr;
      addr = position + 16'(delta);
      return store_mem[addr];
    endfunction

    // Four-point Hermite around the read position; all shifts floor toward minus infinity.
    function logic signed [15:0] hermite_sample();
      longint xm1, x0, x1, x2, f, c, v, w, a, b, h;
      xm1 = tap(-1);
      x0  = tap(0);
      x1  = tap(1);
      x2  = tap(2);
      f   = fraction;
      c   = x1 - xm1;
      v   = 2 * (x0 - x1);
      w   = c + v;
      a   = w + v + x2 - x0;
      b   = w + a;
      h   = ((a * f) >>> 16) - b;
      h   = ((h * f) >>> 16) + c;
      h   = ((h * f) >>> 16) + 2 * x0;
      h   = (h + 1) >>> 1;
      if (h > 32767) h = 32767;
      else if (h < -32768) h = -32768;
      return h[15:0];
    endfunction

    // The position sum is wider than 16 bits when compared with the loop limit; only the
    // stored position wraps.
    function void advance_phase();
      longint unsigned sum;
      int unsigned pos, lend, lstart;
      sum      = fraction + pitch_step();
      pos      = position + 32'(sum >> 16);
      fraction = sum[15:0];
      lend     = lp_limit;
      lstart   = lp_first;
      if (pos >= lend) pos = pos - (lend - lstart);
      position = pos[15:0];
    endfunction

    function void note_item(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                            logic signed [SAMPLE_W-1:0] value);
      case (kind)
        KIND_WRITE: begin
          store_mem[addr] = value;
          written[addr]   = 1'b1;
        end
        KIND_RETRIG: started = 1'b0;
        KIND_TICK: begin
          if (!started) begin
            position = start_offset;
            fraction = '0;
            started  = 1'b1;
            expected_audio.push_back('0);
          end else begin
            expected_audio.push_back(hermite_sample());
          end
          advance_phase();
        end
        default: ;
      endcase
    endfunction

    task check_sample(logic signed [15:0] got);
      logic signed [15:0] want;
      if (expected_audio.size() == 0) begin
        report($sformatf("audio_out %0d arrived with no tick outstanding", got));
      end else begin
        want = expected_audio.pop_front();
        if (got !== want) report($sformatf("audio_out %0d, predicted %0d", got, want));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  hlsv_in_if  in_if ();
  hlsv_out_if out_if ();
  hlsv_cfg_if cfg_if ();

  hermite_looped_sample_voice_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  voice_checker voice;
  int items_sent = 0;
  bit burst_phase = 1'b0;
  int idle_cycles = 0;
  int run_left = 0;
  int stall_left = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Result side: every transfer is checked against the oldest owed sample. Ready follows
  // runs and stalls of random length, so stalls land on every phase of a tick; a long run
  // now and then gives stretches with no back-pressure at all.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) voice.check_sample(out_if.audio_out);
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if (run_left > 0) begin
        run_left--;
      end else begin
        run_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 150) : $urandom_range(0, 5);
        case ($urandom_range(0, 99)) inside
          [0:49]:  stall_left = 0;
          [50:84]: stall_left = $urandom_range(1, 3);
          [85:96]: stall_left = $urandom_range(4, 12);
          default: stall_left = $urandom_range(20, 60);
        endcase
      end
    end
  end

  // Watchdog: a hung handshake on any channel ends the run.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[hermite_looped_sample_voice_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int sender_gap();
    if (burst_phase) return 0;
    case ($urandom_range(0, 99)) inside
      [0:54]:  return 0;
      [55:87]: return $urandom_range(1, 3);
      [88:96]: return $urandom_range(4, 10);
      default: return $urandom_range(20, 60);
    endcase
  endfunction

  // Full-scale values are favored so that the interpolator overshoots into saturation.
  function automatic logic signed [15:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] extreme_u16();
    case ($urandom_range(0, 4))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h0001;
      3:       return 16'hFFFE;
      default: return 16'($urandom);
    endcase
  endfunction

  // Presents one item and holds it until the transfer. Valid stays high when the next
  // item follows at once; the gap that follows, if any, lowers it.
  task automatic send(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                      logic signed [SAMPLE_W-1:0] value);
    int gap;
    in_if.valid        <= 1'b1;
    in_if.kind         <= kind;
    in_if.sample_addr  <= addr;
    in_if.sample_value <= value;
    do @(posedge clk_i); while (!in_if.ready);
    voice.note_item(kind, addr, value);
    if (kind != KIND_UNUSED) items_sent++;
    gap = sender_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // A tick on a running voice reads the four samples around the read position. Any of
  // them not yet written gets a write first, so no read ever hits an unwritten entry.
  task automatic render_tick();
    logic [15:0] addr;
    if (voice.started) begin
      for (int d = -1; d <= 2; d++) begin
        addr = voice.position + 16'(d);
        if (!voice.written[addr]) send(KIND_WRITE, addr, random_sample());
      end
    end
    send(KIND_TICK, 16'($urandom), 16'($urandom));
  endtask

  // Sender holds off until every owed sample has come back. The wait always spans a clock edge
  // so that valid is never lowered and raised in the same step.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (voice.expected_audio.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    voice.note_config(idx, data);
  endtask

  // Registers change only on an idle voice: all results back and the last item finished.
  // The upper bits of the shift word carry noise, since only the low seven are used.
  task automatic program_voice(logic [SHIFT_W-1:0] shift, logic [POS_W-1:0] lstart,
                               logic [POS_W-1:0] lend, logic [POS_W-1:0] start);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(CFG_SHIFT, {9'($urandom), shift});
    write_reg(CFG_LP_FIRST, lstart);
    write_reg(CFG_LP_LIMIT, lend);
    write_reg(CFG_START_OFS, start);
    cfg_if.valid <= 1'b0;
  endtask

  // Settings for one random phase: an ordinary sustain loop half of the time, else the
  // extremes, a reversed loop, or plain noise in every register.
  task automatic random_program();
    logic [SHIFT_W-1:0] shift;
    logic [POS_W-1:0] lstart, lend, start;
    shift = 7'($urandom_range(0, 96) - 48);
    case ($urandom_range(0, 5))
      0, 1, 2: begin
        start  = 16'($urandom);
        lend   = start + 16'($urandom_range(8, 400));
        lstart = lend - 16'($urandom_range(1, 300));
      end
      3: begin
        case ($urandom_range(0, 4))
          0:       shift = 7'h40;
          1:       shift = 7'h3F;
          2:       shift = 7'h50;
          3:       shift = 7'h30;
          default: shift = 7'h00;
        endcase
        lstart = extreme_u16();
        lend   = extreme_u16();
        start  = extreme_u16();
      end
      4: begin
        lstart = 16'($urandom);
        lend   = lstart - 16'($urandom_range(1, 500));
        start  = lend - 16'($urandom_range(0, 200));
      end
      default: begin
        shift  = 7'($urandom);
        lstart = 16'($urandom);
        lend   = 16'($urandom);
        start  = 16'($urandom);
      end
    endcase
    program_voice(shift, lstart, lend, start);
  endtask

  // Mostly ticks and writes into the window just ahead of the read position, so the
  // stored samples change under a running voice; some far writes, retriggers, dropped
  // kinds and full hold-offs of the sender in between.
  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 62) render_tick();
    else if (pick < 80)
      send(KIND_WRITE, voice.position + 16'($urandom_range(0, 43)) - 16'd2, random_sample());
    else if (pick < 88) send(KIND_WRITE, 16'($urandom), random_sample());
    else if (pick < 94) send(KIND_RETRIG, 16'($urandom), 16'($urandom));
    else if (pick < 97) send(KIND_UNUSED, 16'($urandom), 16'($urandom));
    else drain_results();
  endtask

  initial begin
    in_if.valid        = 1'b0;
    in_if.kind         = KIND_WRITE;
    in_if.sample_addr  = '0;
    in_if.sample_value = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = CFG_SHIFT;
    cfg_if.data        = '0;
    out_if.ready       = 1'b0;
    rst_ni             = 1'b0;
    voice              = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: unit pitch, loop end at the top of the address range, start at 0.
    // An undefined kind is dropped, and the very first tick gives silence.
    send(KIND_UNUSED, 16'hFFFF, 16'sh7FFF);
    render_tick();
    // Full-scale samples around address zero. After the retrigger the first tick gives
    // silence and the following ticks read these samples near the bottom of the store.
    send(KIND_WRITE, 16'hFFFF, 16'sh7FFF);
    send(KIND_WRITE, 16'h0000, 16'sh8000);
    send(KIND_WRITE, 16'h0001, 16'sh7FFF);
    send(KIND_WRITE, 16'h0002, 16'sh8000);
    send(KIND_RETRIG, 16'h0000, 16'sh0000);
    render_tick();
    render_tick();
    render_tick();
    // Back-to-back retriggers only clear the running flag.
    send(KIND_RETRIG, 16'hFFFF, 16'shFFFF);
    send(KIND_RETRIG, 16'h5555, 16'shAAAA);
    render_tick();
    render_tick();

    // Slowest pitch of the full shift range, a loop end of zero, playback from the last
    // address so that the reads run past the end of the store.
    program_voice(7'h40, 16'h0000, 16'h0000, 16'hFFFF);
    repeat (4) render_tick();
    // Fastest pitch with reversed loop bounds: after the 16-bit wrap the jump moves the position one back.
    program_voice(7'h3F, 16'hFFFF, 16'h0000, 16'h0000);
    repeat (4) render_tick();

    // Random phases, each under fresh settings and mostly starting from a retrigger.
    while (items_sent < ITEM_COUNT) begin
      random_program();
      burst_phase = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) send(KIND_RETRIG, 16'($urandom), 16'($urandom));
      repeat ($urandom_range(60, 140)) random_item();
    end

    in_if.valid <= 1'b0;
    for (int n = 0; n < IDLE_LIMIT && voice.expected_audio.size() != 0; n++)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (voice.expected_audio.size() != 0)
      voice.report($sformatf("%0d ticks never produced audio", voice.expected_audio.size()));

    if (voice.errors == 0) begin
      $display("[hermite_looped_sample_voice_unit] OK");
    end else begin
      $display("[hermite_looped_sample_voice_unit] ERROR");
    end
    $finish;
  end

endmodule
